[design/sunday_quick_search_matcher_assert.svh]
// assertion helpers shared by the matcher rtl
`ifndef SUNDAY_QUICK_SEARCH_MATCHER_ASSERT_SVH
`define SUNDAY_QUICK_SEARCH_MATCHER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SQS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sqs_pkg.sv]
// ----------------------------------------------------------------------------
// sqs_pkg
// shared types and constants of the sunday quick search matcher
// ----------------------------------------------------------------------------
package sqs_pkg;

  localparam int PATTERN_MAX   = 16;
  localparam int ALPHABET_SIZE = 128;
  localparam int PAT_CAP       = (PATTERN_MAX < 16) ? PATTERN_MAX : 16;
  localparam int WIN_DEPTH     = PATTERN_MAX + 1;
  localparam int WIN_IDX_W     = $clog2(WIN_DEPTH);
  localparam int LEN_W         = $clog2(PAT_CAP + 2);
  localparam int CHAR_W        = 7;
  localparam int POS_W         = 32;
  localparam int IN_TDATA_W    = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_LEN_W     = 5;
  localparam int RES_DEPTH     = 4;
  localparam int RES_PTR_W     = $clog2(RES_DEPTH);
  localparam int RES_CNT_W     = $clog2(RES_DEPTH + 1);

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef char_t win_t [WIN_DEPTH];
  typedef char_t pat_t [PAT_CAP];

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_CHARS_LOW      = 2'd1,
    REG_CHARS_HIGH     = 2'd2
  } cfg_reg_t;

  // verdicts of one evaluation pass
  typedef struct packed {
    logic look_hit;   // window matches at the lookahead alignment
    logic final_hit;  // window matches at the closing alignment
    len_t shift;      // sunday advance for the lookahead char
  } eval_t;

  typedef struct packed {
    logic last;
    pos_t pos;
  } res_t;

  // pattern length 0 acts as 1, anything above capacity as capacity
  function automatic len_t clamp_len(logic [CFG_LEN_W-1:0] v);
    len_t r;
    if (v == '0) begin
      r = len_t'(1);
    end else if (32'(v) > PAT_CAP) begin
      r = len_t'(PAT_CAP);
    end else begin
      r = len_t'(v);
    end
    return r;
  endfunction

endpackage

[design/sqs_eval.sv]
// ----------------------------------------------------------------------------
// sqs_eval
// parallel window compare and last-occurrence search for one text char
// ----------------------------------------------------------------------------
module sqs_eval (
  input  sqs_pkg::win_t  win,   // window with the new char already at entry 0
  input  sqs_pkg::pat_t  pat,
  input  sqs_pkg::len_t  len,
  input  sqs_pkg::char_t chr,
  output sqs_pkg::eval_t ev
);
  import sqs_pkg::*;

  logic                 look_ok;
  logic                 final_ok;
  logic                 found;
  len_t                 last_j;
  logic [WIN_IDX_W-1:0] idx_look;
  logic [WIN_IDX_W-1:0] idx_final;

  // pattern char j sits at window entry len-j (lookahead) or len-1-j (closing)
  always_comb begin
    look_ok   = 1'b1;
    final_ok  = 1'b1;
    idx_look  = '0;
    idx_final = '0;
    for (int j = 0; j < PAT_CAP; j++) begin
      idx_look  = WIN_IDX_W'(len - len_t'(j));
      idx_final = WIN_IDX_W'(len - len_t'(j) - len_t'(1));
      if (len_t'(j) < len) begin
        if (win[idx_look] != pat[j]) look_ok = 1'b0;
        if (win[idx_final] != pat[j]) final_ok = 1'b0;
      end
    end
  end

  // last occurrence of the lookahead char inside the active pattern
  always_comb begin
    found  = 1'b0;
    last_j = '0;
    for (int j = 0; j < PAT_CAP; j++) begin
      if (len_t'(j) < len && pat[j] == chr) begin
        found  = 1'b1;
        last_j = len_t'(j);
      end
    end
  end

  always_comb begin
    ev.look_hit  = look_ok;
    ev.final_hit = final_ok;
    if (int'(chr) >= ALPHABET_SIZE) begin
      ev.shift = len_t'(1);
    end else if (found) begin
      ev.shift = len - last_j;
    end else begin
      ev.shift = len + len_t'(1);
    end
  end

endmodule

[design/sqs_res_fifo.sv]
// ----------------------------------------------------------------------------
// sqs_res_fifo
// small queue taking up to two results per cycle, one out per ready cycle
// ----------------------------------------------------------------------------
module sqs_res_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,   // number of entries written this cycle
  input  sqs_pkg::res_t push_d0,
  input  sqs_pkg::res_t push_d1,
  output logic          room,     // space for two more entries
  output logic          out_valid,
  input  logic          out_ready,
  output sqs_pkg::res_t out_res
);
  import sqs_pkg::*;

  res_t                 mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem[rd_ptr_r];
  assign pop       = out_valid & out_ready;
  assign room      = (cnt_r <= RES_CNT_W'(RES_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    cnt_nxt    = cnt_r + RES_CNT_W'(push_n) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_ptr_r] <= push_d0;
    if (push_n == 2'd2) mem[wr_ptr_r + RES_PTR_W'(1)] <= push_d1;
  end

endmodule

[design/sunday_quick_search_matcher.sv]
// a match found on an accepted char is registered into the result queue for out_*
// throughput: one text char per cycle; results leave one per cycle of out_tready
//   through a four-entry result queue, and input stalls only while that queue
//   lacks room for two entries (a char can yield a lookahead and a closing match)
// reset: synchronous active-low rst_n clears window, counters and queue,
//   sets pattern length to 1 and all pattern chars to zero
// ----------------------------------------------------------------------------
// sunday_quick_search_matcher
// streaming sunday quick search: tests alignments as their lookahead char
// arrives and skips ahead by the bad-char shift of that char
// ----------------------------------------------------------------------------
`include "sunday_quick_search_matcher_assert.svh"

module sunday_quick_search_matcher (
  input  logic                            clk,
  input  logic                            rst_n,
  // text input
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sqs_pkg::IN_TDATA_W-1:0]  in_tdata,   // [6:0] text_char, [7] zero
  input  logic                            in_tlast,   // end_of_text
  // match results
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sqs_pkg::POS_W-1:0]       out_tdata,  // [31:0] match_position
  output logic                            out_tlast,  // last_of_run
  // configuration writes
  input  logic                            cfg_we,
  input  logic [sqs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sqs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sqs_pkg::*;

  // configuration
  len_t  len_r;
  char_t pat_r [PAT_CAP];

  // text state
  char_t win_r [WIN_DEPTH];
  win_t  win_nxt;
  pos_t  count_r, count_nxt;
  pos_t  na_r, na_nxt;          // next alignment to test

  logic  acc;
  char_t chr;
  eval_t ev;
  pos_t  sum;                   // next alignment plus pattern length
  logic  tested;                // this char is the lookahead of the alignment
  logic  final_due;             // closing alignment ends on this char
  logic  look_push;
  logic  fin_push;
  logic  room;
  logic [1:0] push_n;
  res_t  d0, d1;
  res_t  head;

  assign acc = in_tvalid & in_tready;
  assign chr = in_tdata[CHAR_W-1:0];
  assign in_tready = room;

  // window as it looks with the new char shifted in
  always_comb begin
    win_nxt[0] = chr;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  sqs_eval u_eval (
    .win (win_nxt),
    .pat (pat_r),
    .len (len_r),
    .chr (chr),
    .ev  (ev)
  );

  // once tested, the closing alignment lines up only for a shift of one
  always_comb begin
    sum       = na_r + POS_W'(len_r);
    tested    = (count_r == sum);
    final_due = in_tlast & (tested ? (ev.shift == len_t'(1)) : (count_r + 1 == sum));
    look_push = acc & tested & ev.look_hit;
    fin_push  = acc & final_due & ev.final_hit;
    na_nxt    = tested ? (na_r + POS_W'(ev.shift)) : na_r;
    count_nxt = count_r + 1;
  end

  // compact the results of this char into queue order, last flag on the final one
  always_comb begin
    push_n  = 2'(look_push) + 2'(fin_push);
    d0.pos  = look_push ? na_r : na_nxt;
    d0.last = ~(look_push & fin_push);
    d1.pos  = na_nxt;
    d1.last = 1'b1;
  end

  sqs_res_fifo u_res (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_d0   (d0),
    .push_d1   (d1),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  assign out_tdata = head.pos;
  assign out_tlast = head.last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= len_t'(1);
      for (int j = 0; j < PAT_CAP; j++) pat_r[j] <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH: len_r <= clamp_len(cfg_data[CFG_LEN_W-1:0]);
        REG_CHARS_LOW: begin
          for (int j = 0; j < PAT_CAP; j++) begin
            if (j < 8) pat_r[j] <= cfg_data[8*(j%8) +: CHAR_W];
          end
        end
        REG_CHARS_HIGH: begin
          for (int j = 0; j < PAT_CAP; j++) begin
            if (j >= 8) pat_r[j] <= cfg_data[8*(j%8) +: CHAR_W];
          end
        end
        default: ;
      endcase
    end
  end

  // text state, cleared again after the end-of-text char
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      na_r    <= '0;
      for (int i = 0; i < WIN_DEPTH; i++) win_r[i] <= '0;
    end else if (acc) begin
      if (in_tlast) begin
        count_r <= '0;
        na_r    <= '0;
        for (int i = 0; i < WIN_DEPTH; i++) win_r[i] <= '0;
      end else begin
        count_r <= count_nxt;
        na_r    <= na_nxt;
        for (int i = 0; i < WIN_DEPTH; i++) win_r[i] <= win_nxt[i];
      end
    end
  end

  `SQS_ASSERT_NOW(a_shift_range, tested, (ev.shift != '0) && (ev.shift <= len_r + len_t'(1)), "shift out of range")
  `SQS_ASSERT_NOW(a_push_room, look_push || fin_push, room, "result pushed without queue room")
  `SQS_ASSERT_NEXT(a_restart, acc && in_tlast, (count_r == '0) && (na_r == '0), "no restart after end of text")
  `SQS_ASSERT_NEXT(a_count_step, acc && !in_tlast, count_r == $past(count_r) + 1, "char count did not advance")

endmodule

[dv/sunday_quick_search_matcher_tb.sv]
// ----------------------------------------------------------------------------
// sunday_quick_search_matcher_tb
// self-checking bench for the streaming sunday quick search matcher: a short
// table of directed texts, then random patterns and texts under three idling
// mixes, every match checked against a typed row result or a local bad-char predictor
// ----------------------------------------------------------------------------
module sunday_quick_search_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sqs_pkg::*;

  localparam int ITEMS_PER_SETTING = 100;  // 3 idling mixes x 3 settings
  localparam int SETTLE_CYCLES     = 8;    // quiet cycles after every expected match has drained
  localparam int HOLD_CYCLES       = 300;  // long receiver hold-off
  localparam int STALL_LIMIT       = 5000; // cycles with no transfer at all

  // one expected match transfer
  typedef struct packed {
    pos_t pos;
    logic last;
  } match_t;

  // matches caused by one text char, in output order
  typedef struct packed {
    logic [1:0] cnt;
    pos_t       first;
    pos_t       second;
  } step_hits_t;

  typedef enum logic {ROW_WRITE, ROW_CHAR} row_kind_e;

  // directed row: a register write, or a char sent reps times with end of
  // text only on the last copy; typed rows carry their result for that copy
  typedef struct packed {
    row_kind_e  kind;
    cfg_reg_t   reg_idx;
    logic [63:0] value;
    char_t      ch;
    logic [4:0] reps;
    logic       eot;
    logic       typed;
    logic [1:0] n_typed;
    pos_t       pos;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [14] = '{
    // after reset: length 1, pattern char zero, so a lone zero char matches
    '{ROW_CHAR,  REG_PATTERN_LENGTH, 64'd0, 7'h00, 5'd1,  1'b1, 1'b1, 2'd1, 32'd0},
    '{ROW_CHAR,  REG_PATTERN_LENGTH, 64'd0, 7'h7f, 5'd1,  1'b1, 1'b1, 2'd0, 32'd0},
    // lookahead match and closing match on the same final char
    '{ROW_CHAR,  REG_PATTERN_LENGTH, 64'd0, 7'h00, 5'd3,  1'b1, 1'b0, 2'd0, 32'd0},
    // length zero acts as one; bit 7 of a pattern byte is ignored
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'd0, 7'h00, 5'd0,  1'b0, 1'b0, 2'd0, 32'd0},
    '{ROW_WRITE, REG_CHARS_LOW, 64'h8080_8080_8080_80c1, 7'h00, 5'd0, 1'b0, 1'b0, 2'd0,
      32'd0},
    '{ROW_CHAR,  REG_PATTERN_LENGTH, 64'd0, 7'h41, 5'd2,  1'b1, 1'b0, 2'd0, 32'd0},
    // text shorter than the pattern reports nothing
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'd3, 7'h00, 5'd0,  1'b0, 1'b0, 2'd0, 32'd0},
    '{ROW_WRITE, REG_CHARS_LOW, 64'h0000_0000_00e3_62e1, 7'h00, 5'd0, 1'b0, 1'b0, 2'd0,
      32'd0},
    '{ROW_CHAR,  REG_PATTERN_LENGTH, 64'd0, 7'h61, 5'd1,  1'b0, 1'b1, 2'd0, 32'd0},
    '{ROW_CHAR,  REG_PATTERN_LENGTH, 64'd0, 7'h62, 5'd1,  1'b1, 1'b1, 2'd0, 32'd0},
    // length above capacity acts as 16; full pattern of 7f matches at zero
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'd31, 7'h00, 5'd0, 1'b0, 1'b0, 2'd0, 32'd0},
    '{ROW_WRITE, REG_CHARS_LOW,  '1, 7'h00, 5'd0,  1'b0, 1'b0, 2'd0, 32'd0},
    '{ROW_WRITE, REG_CHARS_HIGH, '1, 7'h00, 5'd0,  1'b0, 1'b0, 2'd0, 32'd0},
    '{ROW_CHAR,  REG_PATTERN_LENGTH, 64'd0, 7'h7f, 5'd16, 1'b1, 1'b1, 2'd1, 32'd0}
  };

  // dut signals, the driven ones known from time zero
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;   // [6:0] text_char, [7] zero
  logic                  in_tlast   = 1'b0; // end_of_text
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [POS_W-1:0]      out_tdata;         // [31:0] match_position
  logic                  out_tlast;         // last_of_run
  logic                  cfg_we     = 1'b0;
  cfg_reg_t              cfg_index  = REG_PATTERN_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // predictor state: text tail (entry 0 newest), char index, next alignment
  char_t       text_tail [WIN_DEPTH];
  pos_t        seen_chars;
  pos_t        next_start;
  logic [4:0]  plen_reg;
  logic [63:0] pchars_lo;
  logic [63:0] pchars_hi;

  match_t pending_matches [$];

  // idling and hold-off control, shared with the receiver process
  int send_idle_pct = 17;
  int recv_idle_pct = 85;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  int mismatch_count = 0;
  int matches_seen   = 0;
  int chars_sent     = 0;
  int texts_sent     = 0;
  int reg_writes     = 0;
  int stall_cycles   = 0;

  sunday_quick_search_matcher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // length register as used: zero acts as one, capped at capacity
  function automatic int active_len();
    if (plen_reg == 5'd0) return 1;
    if (int'(plen_reg) > PAT_CAP) return PAT_CAP;
    return int'(plen_reg);
  endfunction

  function automatic char_t pattern_char(int j);
    logic [63:0] w;
    w = (j < 8) ? pchars_lo : pchars_hi;
    return w[8*(j%8) +: CHAR_W];
  endfunction

  // m minus last occurrence of c in the pattern, m+1 if c is absent
  function automatic int bad_char_shift(char_t c, int m);
    if (int'(c) >= ALPHABET_SIZE) return 1;
    for (int j = m; j > 0; j--) begin
      if (pattern_char(j - 1) == c) return m - (j - 1);
    end
    return m + 1;
  endfunction

  // pattern char j against tail entry base - j
  function automatic bit window_equal(int base, int m);
    for (int j = 0; j < m; j++) begin
      if (base - j < 0 || base - j >= WIN_DEPTH) return 1'b0;
      if (text_tail[base - j] != pattern_char(j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_text();
    for (int i = 0; i < WIN_DEPTH; i++) text_tail[i] = '0;
    seen_chars = '0;
    next_start = '0;
  endfunction

  function automatic step_hits_t predict_matches(char_t c, logic eot);
    step_hits_t h;
    int         m;
    pos_t       k;
    h = '0;
    m = active_len();
    k = seen_chars;
    for (int i = WIN_DEPTH - 1; i > 0; i--) text_tail[i] = text_tail[i-1];
    text_tail[0] = c;
    // alignment due: its lookahead char just arrived
    if (k == next_start + pos_t'(m)) begin
      if (window_equal(m, m)) begin
        h.first = next_start;
        h.cnt   = 2'd1;
      end
      next_start = next_start + pos_t'(bad_char_shift(c, m));
    end
    // closing alignment ends on the final char, no lookahead
    if (eot && (next_start + pos_t'(m) == k + pos_t'(1))) begin
      if (window_equal(m - 1, m)) begin
        if (h.cnt == 2'd0) h.first = next_start;
        else h.second = next_start;
        h.cnt = h.cnt + 2'd1;
      end
    end
    seen_chars = k + pos_t'(1);
    if (eot) clear_text();
    return h;
  endfunction

  // ------------------------------------------------------------------ drivers

  // one char transfer; expectations queued once it is accepted
  task automatic send_char(char_t c, logic eot, bit use_typed, step_hits_t typed);
    step_hits_t h;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, c};
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
    h = predict_matches(c, eot);
    if (use_typed) h = typed;
    for (int i = 0; i < h.cnt; i++) begin
      pending_matches.push_back('{pos: (i == 0) ? h.first : h.second,
                                  last: (i == h.cnt - 1)});
    end
    chars_sent++;
  endtask

  // caller lowers cfg_we after the last write of a batch
  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_PATTERN_LENGTH: plen_reg  = value[4:0];
      REG_CHARS_LOW:      pchars_lo = value;
      REG_CHARS_HIGH:     pchars_hi = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  // stop offering, let every expected match drain, then a few quiet cycles
  task automatic wait_all_matched();
    in_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus
  initial begin : stimulus
    stim_row_t   row;
    step_hits_t  typed;
    bit          writing;
    bit          narrow;
    int          plen_pick;
    int          choice;
    int          m;
    int          tlen;
    int          copy_idx;
    int          r;
    int          in_setting;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [7:0]  pbyte;
    char_t       base_char;
    char_t       ch;

    clear_text();
    plen_reg  = 5'd1;
    pchars_lo = '0;
    pchars_hi = '0;
    lo        = '0;
    hi        = '0;
    writing   = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_WRITE) begin
        if (!writing) wait_all_matched();
        write_reg(row.reg_idx, row.value);
        writing = 1'b1;
      end else begin
        if (writing) cfg_we <= 1'b0;
        writing = 1'b0;
        typed = '{cnt: row.n_typed, first: row.pos, second: '0};
        for (int k = 0; k < row.reps; k++) begin
          send_char(row.ch, row.eot && (k == row.reps - 1),
                    row.typed && (k == row.reps - 1), typed);
        end
        if (row.eot) texts_sent++;
      end
    end

    // random part: three idling mixes, three pattern settings in each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 17; recv_idle_pct = 85; end
        1:       begin send_idle_pct = 85; recv_idle_pct = 17; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int s = 0; s < 3; s++) begin
        // first settings walk the length extremes, later ones are random
        choice = phase * 3 + s;
        if (choice >= 4) choice = $urandom_range(4, 9);
        case (choice)
          0:       plen_pick = 16;
          1:       plen_pick = 1;
          2:       plen_pick = 0;
          3:       plen_pick = $urandom_range(17, 31);
          default: plen_pick = ($urandom_range(3) == 0) ? $urandom_range(1, 16)
                                                        : $urandom_range(1, 6);
        endcase
        // narrow alphabet gives overlapping and repeated occurrences
        narrow    = ($urandom_range(3) != 0);
        base_char = char_t'($urandom_range(0, 125));
        for (int j = 0; j < 16; j++) begin
          pbyte[6:0] = narrow ? char_t'(base_char + char_t'($urandom_range(0, 2)))
                              : char_t'($urandom_range(0, 127));
          pbyte[7]   = 1'($urandom_range(0, 1));
          if (j < 8) lo[8*j +: 8] = pbyte;
          else hi[8*(j-8) +: 8] = pbyte;
        end

        wait_all_matched();
        write_reg(REG_PATTERN_LENGTH, 64'(plen_pick));
        write_reg(REG_CHARS_LOW, lo);
        write_reg(REG_CHARS_HIGH, hi);
        cfg_we <= 1'b0;
        m = active_len();

        in_setting = 0;
        while (in_setting < ITEMS_PER_SETTING) begin
          // mostly short texts, some longer ones
          tlen = ($urandom_range(4) != 0) ? $urandom_range(1, 2 * m + 4)
                                          : $urandom_range(1, 60);
          copy_idx = 0;
          for (int t = 0; t < tlen; t++) begin
            r = $urandom_range(99);
            if (r < 45) begin
              // walk through the pattern, sometimes breaking off
              ch = pattern_char(copy_idx);
              copy_idx = ($urandom_range(9) == 0) ? 0 : (copy_idx + 1) % m;
            end else if (r < 85) begin
              ch = pattern_char($urandom_range(0, m - 1));
            end else begin
              ch = char_t'($urandom_range(0, 127));
            end
            send_char(ch, t == tlen - 1, 1'b0, '0);
            in_setting++;
            // receiver holds off while the sender keeps offering; length one
            // makes most chars match, so the result queue surely fills
            if (phase == 0 && s == 1 && in_setting == 20) hold_requests++;
            // sender pauses mid-stream until every match is out
            if (phase == 1 && s == 2 && in_setting == 40) wait_all_matched();
          end
          texts_sent++;
        end
      end
    end

    wait_all_matched();

    $display("covered %0d texts, %0d chars, %0d matches checked, %0d register writes",
             texts_sent, chars_sent, matches_seen, reg_writes);
    $display("idling mixes 17/85, 85/17 and none, one %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (mismatch_count == 0 && pending_matches.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // random ready, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ----------------------------------------------------------------- checker
  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_matches.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected match transfer: position %0d last %0b",
                   out_tdata, out_tlast);
        end
      end else begin
        want = pending_matches.pop_front();
        if (out_tdata !== want.pos || out_tlast !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("match mismatch: expected position %0d last %0b, got %0d last %0b",
                     want.pos, want.last, out_tdata, out_tlast);
          end
        end
        matches_seen++;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  // any transfer on either side restarts the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

[sunday_quick_search_matcher.f]
+incdir+design
design/sqs_pkg.sv
design/sqs_eval.sv
design/sqs_res_fifo.sv
design/sunday_quick_search_matcher.sv
dv/sunday_quick_search_matcher_tb.sv
